[src/cfrh_pkg.sv]
// Shared types and constants for the change-filtered RGB to HSV block.
package cfrh_pkg;

    localparam int unsigned LimitW  = 11;
    localparam logic [LimitW-1:0] LimitReset = 11'd1201;
    localparam int unsigned QDepth  = 2;
    localparam int unsigned DivW    = 15;  // dividend width: 100*255 < 2^15
    localparam int unsigned QuoW    = 7;   // quotients stay below 128

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    typedef struct packed {
        logic [8:0] hue_deg;
        logic [6:0] sat_pct;
        logic [6:0] val_pct;
    } hsv_t;

    typedef enum logic [1:0] {
        SEC_NONE = 2'd0,
        SEC_RED  = 2'd1,
        SEC_GRN  = 2'd2,
        SEC_BLU  = 2'd3
    } sector_t;

    // classified request handed from the front to the back
    typedef struct packed {
        sector_t    sector;
        logic       neg;        // hue term below the sector base
        logic [DivW-1:0] hue_num;  // 60*|diff| (+c-1 when negative)
        logic [7:0] chroma;
        logic [DivW-1:0] sat_num;  // 100*c
        logic [7:0] maxv;
        logic [6:0] val_pct;
    } job_t;

    localparam logic [3:0] RegRepeatLimit = 4'd0;

endpackage

[src/cfrh_front.sv]
// Front end: change filter and classification of each accepted triple.
module cfrh_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  cfrh_pkg::rgb_t      s_data,
    input  logic [10:0]         repeat_limit,
    input  logic                q_ready,
    output logic                q_push,
    output cfrh_pkg::job_t      q_job
);
    import cfrh_pkg::*;

    logic [7:0] last_r_reg, last_g_reg, last_b_reg;
    logic [LimitW-1:0] count_reg;
    logic acc, repeat_hit;
    logic [7:0] r, g, b, mx, mn, c, pos, neg;
    logic [DivW-1:0] mag;
    job_t job;

    assign r = s_data.red;
    assign g = s_data.green;
    assign b = s_data.blue;
    assign s_ready = q_ready;
    assign acc = s_valid && s_ready;
    assign repeat_hit = (r == last_r_reg) && (g == last_g_reg) && (b == last_b_reg)
                        && (count_reg < repeat_limit);

    always_comb begin
        mx = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        mn = r;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        c = mx - mn;
        pos = 8'd0;
        neg = 8'd0;
        job.sector = SEC_NONE;
        if (c == 8'd0) begin
            job.sector = SEC_NONE;
        end else if (mx == r) begin
            job.sector = SEC_RED; pos = g; neg = b;
        end else if (mx == g) begin
            job.sector = SEC_GRN; pos = b; neg = r;
        end else begin
            job.sector = SEC_BLU; pos = r; neg = g;
        end
        job.neg = pos < neg;
        mag = (pos >= neg) ? DivW'(pos - neg) : DivW'(neg - pos);
        job.hue_num = job.neg ? DivW'(mag * 60 + DivW'(c) - 1) : DivW'(mag * 60);
        job.chroma = c;
        job.sat_num = DivW'(c * 100);
        job.maxv = mx;
        // 100*max/255 via reciprocal: (x*257+257)>>16 for x=100*max
        job.val_pct = 7'((({8'd0, DivW'(mx * 100)} * 23'd257 + 23'd257) >> 16));
    end

    assign q_push = acc && !repeat_hit;
    assign q_job = job;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_r_reg <= '0; last_g_reg <= '0; last_b_reg <= '0;
            count_reg <= '0;
        end else if (acc) begin
            if (repeat_hit) begin
                count_reg <= count_reg + 1'b1;
            end else begin
                count_reg <= '0;
                last_r_reg <= r; last_g_reg <= g; last_b_reg <= b;
            end
        end
    end
endmodule

[src/cfrh_queue.sv]
// Two-entry queue between the front and back ends.
module cfrh_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  cfrh_pkg::job_t push_job,
    output logic           can_push,
    input  logic           pop,
    output logic           not_empty,
    output cfrh_pkg::job_t head
);
    import cfrh_pkg::*;

    job_t mem_reg [QDepth];
    logic rd_reg, wr_reg;
    logic [1:0] cnt_reg;

    assign can_push = cnt_reg != 2'(QDepth);
    assign not_empty = cnt_reg != 2'd0;
    assign head = mem_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_reg] <= push_job;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_reg <= 1'b0; wr_reg <= 1'b0; cnt_reg <= '0;
        end else begin
            if (push) wr_reg <= ~wr_reg;
            if (pop) rd_reg <= ~rd_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule

[src/cfrh_back.sv]
// Back end: restoring dividers for hue and saturation, then the result.
module cfrh_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_valid,
    input  cfrh_pkg::job_t q_job,
    output logic           q_pop,
    output logic           m_valid,
    input  logic           m_ready,
    output cfrh_pkg::hsv_t m_data
);
    import cfrh_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_OUT  = 3'b100
    } state_t;

    state_t state_reg;
    job_t job_reg;
    logic [2:0] step_reg;
    logic [DivW-1:0] hrem_reg, srem_reg;
    logic [QuoW-1:0] hq_reg, sq_reg;
    logic [DivW-1:0] hsub, ssub;
    logic [8:0] hue;
    logic [2:0] bitpos;

    assign bitpos = 3'(QuoW - 1) - step_reg;
    assign hsub = DivW'(job_reg.chroma) << bitpos;
    assign ssub = DivW'(job_reg.maxv) << bitpos;
    assign q_pop = (state_reg == ST_IDLE) && q_valid;
    assign m_valid = state_reg == ST_OUT;
    // quotients and job stay put while the result waits
    assign m_data = {hue, sq_reg, job_reg.val_pct};

    always_comb begin
        case (job_reg.sector)
            SEC_RED: hue = job_reg.neg ? 9'(360 - hq_reg) : 9'(hq_reg);
            SEC_GRN: hue = job_reg.neg ? 9'(120 - hq_reg) : 9'(120 + hq_reg);
            SEC_BLU: hue = job_reg.neg ? 9'(240 - hq_reg) : 9'(240 + hq_reg);
            default: hue = 9'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            case (state_reg)
                ST_IDLE: if (q_valid) state_reg <= ST_DIV;
                ST_DIV:  if (step_reg == 3'(QuoW - 1)) state_reg <= ST_OUT;
                ST_OUT:  if (m_ready) state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // one quotient bit per cycle for both divisions
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                job_reg <= q_job;
                hrem_reg <= q_job.hue_num;
                srem_reg <= q_job.sat_num;
                step_reg <= '0;
                hq_reg <= '0;
                sq_reg <= '0;
            end
            ST_DIV: begin
                step_reg <= step_reg + 1'b1;
                if (job_reg.chroma != 8'd0 && hrem_reg >= hsub) begin
                    hrem_reg <= hrem_reg - hsub;
                    hq_reg[bitpos] <= 1'b1;
                end
                if (job_reg.maxv != 8'd0 && srem_reg >= ssub) begin
                    srem_reg <= srem_reg - ssub;
                    sq_reg[bitpos] <= 1'b1;
                end
            end
            default: begin
            end
        endcase
    end
endmodule

[src/change_filtered_rgb_to_hsv_core.sv]
// Top level of the change-filtered RGB to HSV converter.
// Accepts one RGB triple per request; a triple equal to the last one sent is
// dropped until repeat_limit repeats have passed. Each sent triple goes
// through the queue to the back end: two 7-step restoring dividers (hue and
// saturation), one quotient bit per cycle. The back end steps through idle,
// 7 divide steps and output, and takes no new triple until its result is
// taken. A two-entry queue lets the front accept while the back works;
// dropped repeats never enter the queue. Register 0 at address 0 is
// repeat_limit (reset 1201).
module change_filtered_rgb_to_hsv_core (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  cfrh_pkg::rgb_t s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output cfrh_pkg::hsv_t m_data,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [1:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);
    import cfrh_pkg::*;

    logic [LimitW-1:0] limit_reg;
    logic q_push, q_can, q_pop, q_ne;
    job_t q_in, q_head;

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {21'd0, limit_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LimitReset;
        end else if (psel && penable && pwrite && paddr == RegRepeatLimit[1:0]) begin
            limit_reg <= pwdata[LimitW-1:0];
        end
    end

    cfrh_front u_front (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_data(s_data), .repeat_limit(limit_reg), .q_ready(q_can),
        .q_push(q_push), .q_job(q_in)
    );

    cfrh_queue u_queue (
        .aclk(aclk), .aresetn(aresetn), .push(q_push), .push_job(q_in),
        .can_push(q_can), .pop(q_pop), .not_empty(q_ne), .head(q_head)
    );

    cfrh_back u_back (
        .aclk(aclk), .aresetn(aresetn), .q_valid(q_ne), .q_job(q_head),
        .q_pop(q_pop), .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

`ifndef NO_ASSERTIONS
    a_hue_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.hue_deg < 9'd360) else $error("hue out of range");
    a_pct_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.sat_pct <= 7'd100 && m_data.val_pct <= 7'd100))
        else $error("percent out of range");
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> q_can) else $error("queue overflow");
`endif
endmodule
